// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion helpers shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// implication checked on every rising clk edge outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/sapq_pkg.sv =====
// ----------------------------------------------------------------------------
// sapq_pkg
// shared constants and types of the sorted array priority queue
// ----------------------------------------------------------------------------
package sapq_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int PRIO_W    = 16;
    localparam int OCC_W     = 7;
    localparam int STAT_W    = 2;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [STAT_W-1:0] status;
        logic [OCC_W-1:0]  occupancy;
    } result_t;

endpackage

// ===== hw/rtl/sapq_ram.sv =====
// ----------------------------------------------------------------------------
// sapq_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module sapq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/sapq_ctrl.sv =====
// ----------------------------------------------------------------------------
// sapq_ctrl
// request sequencer: walks the sorted store one entry a cycle to insert or
// remove, with a read issued in the cycle before each write back
// ----------------------------------------------------------------------------
module sapq_ctrl import sapq_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF,
    localparam int ADDR_W = $clog2(DEPTH),
    localparam int CNT_W  = $clog2(DEPTH + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              in_kind,
    input  logic [PRIO_W-1:0] in_prio,
    output logic              res_valid,
    input  logic              res_ready,
    output result_t           res,
    output logic [CNT_W-1:0]  count,
    output logic              rd_en,
    output logic [ADDR_W-1:0] rd_addr,
    input  logic [PRIO_W-1:0] rd_data,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output logic [PRIO_W-1:0] wr_data
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_PUSH      = 3'd1;
    localparam logic [2:0] S_PUSH_LAST = 3'd2;
    localparam logic [2:0] S_POP       = 3'd3;
    localparam logic [2:0] S_DONE      = 3'd4;

    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_TWO   = CNT_W'(2);
    localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(DEPTH);

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [PRIO_W-1:0] prio_reg, prio_next;
    logic [PRIO_W-1:0] top_reg, top_next;
    result_t           res_reg, res_next;
    logic [CNT_W-1:0]  rd_idx, wr_idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        prio_reg <= prio_next;
        top_reg  <= top_next;
        res_reg  <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        prio_next  = prio_reg;
        top_next   = top_reg;
        res_next   = res_reg;
        rd_en      = 1'b0;
        rd_idx     = '0;
        wr_en      = 1'b0;
        wr_idx     = '0;
        wr_data    = prio_reg;
        in_ready   = 1'b0;
        res_valid  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready  = 1'b1;
                prio_next = in_prio;
                if (in_valid)
                begin
                    if (in_kind == REQ_PUSH)
                    begin
                        if (count_reg >= CNT_DEPTH)
                        begin
                            res_next   = '{prio: '0, status: ST_FULL,
                                           occupancy: OCC_W'(count_reg)};
                            state_next = S_DONE;
                        end
                        else if (count_reg == '0)
                        begin
                            wr_en      = 1'b1;
                            wr_data    = in_prio;
                            count_next = CNT_ONE;
                            res_next   = '{prio: '0, status: ST_OK,
                                           occupancy: OCC_W'(CNT_ONE)};
                            state_next = S_DONE;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_idx     = count_reg - CNT_ONE;
                            idx_next   = count_reg;
                            state_next = S_PUSH;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            res_next   = '{prio: '0, status: ST_EMPTY,
                                           occupancy: OCC_W'(count_reg)};
                            state_next = S_DONE;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_idx     = '0;
                            idx_next   = '0;
                            state_next = S_POP;
                        end
                    end
                end
            end

            S_PUSH:
            begin
                wr_en  = 1'b1;
                wr_idx = idx_reg;
                if (rd_data < prio_reg)
                begin
                    wr_data  = rd_data;
                    idx_next = idx_reg - CNT_ONE;
                    if (idx_reg == CNT_ONE)
                    begin
                        state_next = S_PUSH_LAST;
                    end
                    else
                    begin
                        rd_en  = 1'b1;
                        rd_idx = idx_reg - CNT_TWO;
                    end
                end
                else
                begin
                    wr_data    = prio_reg;
                    count_next = count_reg + CNT_ONE;
                    res_next   = '{prio: '0, status: ST_OK,
                                   occupancy: OCC_W'(count_reg + CNT_ONE)};
                    state_next = S_DONE;
                end
            end

            S_PUSH_LAST:
            begin
                wr_en      = 1'b1;
                wr_idx     = '0;
                wr_data    = prio_reg;
                count_next = count_reg + CNT_ONE;
                res_next   = '{prio: '0, status: ST_OK,
                               occupancy: OCC_W'(count_reg + CNT_ONE)};
                state_next = S_DONE;
            end

            S_POP:
            begin
                if (idx_reg == '0)
                begin
                    top_next = rd_data;
                end
                else
                begin
                    wr_en   = 1'b1;
                    wr_idx  = idx_reg - CNT_ONE;
                    wr_data = rd_data;
                end
                if ((idx_reg + CNT_ONE) < count_reg)
                begin
                    rd_en    = 1'b1;
                    rd_idx   = idx_reg + CNT_ONE;
                    idx_next = idx_reg + CNT_ONE;
                end
                else
                begin
                    count_next = count_reg - CNT_ONE;
                    res_next   = '{prio: (idx_reg == '0) ? rd_data : top_reg,
                                   status: ST_OK,
                                   occupancy: OCC_W'(count_reg - CNT_ONE)};
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rd_addr = rd_idx[ADDR_W-1:0];
    assign wr_addr = wr_idx[ADDR_W-1:0];
    assign res     = res_reg;
    assign count   = count_reg;

endmodule

// ===== hw/rtl/sorted_array_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_array_priority_queue
// max priority queue kept in descending order in one ram
//
// channel  dir  tdata                                 tuser
// s_axis   in   [15:0] priority_in                    [0] req_type
// m_axis   out  [15:0] priority_out, [22:16] occupancy [1:0] status
//
// a push walks the ram from the tail to its insertion point and a pop walks
// every entry from the head, one entry a cycle; full and empty requests skip
// the walk. one item is in work at a time; the result register lets the
// next item in while a result waits. reset empties the queue at once.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_array_priority_queue import sapq_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] priority_in
    input  logic [0:0]  s_tuser,   // [0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [15:0] priority_out, [22:16] occupancy
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    logic              rd_en, wr_en;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic [PRIO_W-1:0] rd_data, wr_data;
    logic              res_valid, res_ready;
    result_t           res;
    logic [CNT_W-1:0]  count;

    logic              m_tvalid_reg, m_tvalid_next;
    result_t           out_reg, out_next;

    sapq_ram #(
        .WIDTH (PRIO_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sapq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (s_tuser[0]),
        .in_prio   (s_tdata[PRIO_W-1:0]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .count     (count),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        out_next      = out_reg;
        if (res_ready)
        begin
            m_tvalid_next = res_valid;
            if (res_valid)
            begin
                out_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_tvalid      = m_tvalid_reg;
    assign m_tdata[15:0] = out_reg.prio;
    assign m_tdata[22:16] = out_reg.occupancy;
    assign m_tdata[23]   = 1'b0;
    assign m_tuser       = out_reg.status;

    `ASSERT_CLK(a_count_bound, count <= CNT_W'(DEPTH), "entry count above depth")
    `ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "item taken while busy")
    `ASSERT_IMPL(a_refused_zero, m_tvalid && (m_tuser != ST_OK), m_tdata[15:0] == '0,
        "refused request carries a priority")
    `ASSERT_IMPL(a_status_code, m_tvalid, m_tuser <= ST_EMPTY, "undefined status code")
    `ASSERT_IMPL(a_no_mem_clash, wr_en && rd_en, wr_addr != rd_addr,
        "read and write hit the same entry")

endmodule
